@@ src/mmscl_pkg.sv @@
// Shared types and constants of the min-max feature scaler.
`default_nettype none

package mmscl_pkg;

   // Fixed widths of the request and response fields.
   localparam int FI_W      = 6;
   localparam int SCALED_W  = 16;
   localparam int DIV_CNT_W = $clog2(SCALED_W);

   // Operation code of a request.
   localparam logic OP_OBSERVE = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic update_wr;
      logic set_result;
      logic div_start;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic is_observe;
      logic need_div;
      logic div_last;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

@@ src/mmscl_req_if.sv @@
// Request channel of the min-max feature scaler.
`default_nettype none

interface mmscl_req_if
   import mmscl_pkg::*;
#(
   parameter int VALUE_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic                   operation;
   logic [FI_W-1:0]        feature_index;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, operation, feature_index, value, input ready);
   modport sink   (input valid, operation, feature_index, value, output ready);
endinterface

`default_nettype wire

@@ src/mmscl_rsp_if.sv @@
// Response channel of the min-max feature scaler.
`default_nettype none

interface mmscl_rsp_if
   import mmscl_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SCALED_W-1:0] scaled;
   logic                range_valid;
   logic                clipped;

   modport source (output valid, scaled, range_valid, clipped, input ready);
   modport sink   (input valid, scaled, range_valid, clipped, output ready);
endinterface

`default_nettype wire

@@ src/mmscl_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module mmscl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                  wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

@@ src/mmscl_ctrl.sv @@
// Controller state machine of the min-max feature scaler.
`default_nettype none

module mmscl_ctrl
   import mmscl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire sts_type sts,
   output      cmd_type cmd
);
   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            // The stored range arrives from the RAM at the end of this cycle.
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (sts.is_observe) begin
               cmd.update_wr = 1'b1;
               state_in      = ST_IDLE;
            end else if (sts.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               cmd.set_result = 1'b1;
               state_in       = ST_OUTPUT;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end
endmodule

`default_nettype wire

@@ src/mmscl_dpath.sv @@
// Datapath of the min-max feature scaler: range store, compare logic and divider.
`default_nettype none

module mmscl_dpath
   import mmscl_pkg::*;
#(
   parameter int NUM_FEATURES = 64,
   parameter int VALUE_WIDTH  = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output      sts_type                sts,
   input  wire logic                   req_operation,
   input  wire logic [FI_W-1:0]        req_feature_index,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   input  wire logic                   rsp_ready,
   output      logic                   rsp_valid,
   output      logic [SCALED_W-1:0]    rsp_scaled,
   output      logic                   rsp_range_valid,
   output      logic                   rsp_clipped
);
   localparam int ADDR_W    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   localparam int IDX_EXT_W = (ADDR_W > FI_W) ? ADDR_W : FI_W;
   localparam int VW        = VALUE_WIDTH;
   localparam logic [VW-1:0] VAL_LARGEST  = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] VAL_SMALLEST = {1'b1, {(VW-1){1'b0}}};

   // Latched request.
   logic            op_ff,  op_in;
   logic [FI_W-1:0] idx_ff, idx_in;
   logic [VW-1:0]   val_ff, val_in;

   // Divider and pending result.
   logic [SCALED_W-1:0]  quot_ff, quot_in;
   logic [VW-1:0]        rem_ff, rem_in;
   logic [VW-1:0]        den_ff, den_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 res_valid_ff, res_valid_in;
   logic                 res_clip_ff, res_clip_in;

   // Clearing pass address.
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SCALED_W-1:0] rsp_scaled_ff, rsp_scaled_in;
   logic                rsp_range_valid_ff, rsp_range_valid_in;
   logic                rsp_clipped_ff, rsp_clipped_in;

   logic [IDX_EXT_W-1:0] idx_ext;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   logic                 wr_en;
   logic [2*VW-1:0]      wr_data;
   logic [2*VW-1:0]      rd_word;
   logic                 in_range;

   logic signed [VW-1:0] v_s;
   logic signed [VW-1:0] lo_s;
   logic signed [VW-1:0] hi_s;
   logic [VW:0]          diff_v;
   logic [VW:0]          span;
   logic [VW-1:0]        new_lo;
   logic [VW-1:0]        new_hi;

   logic [SCALED_W-1:0] direct_scaled;
   logic                direct_valid;
   logic                direct_clip;
   logic                need_div;

   logic [VW:0] rem2;
   logic [VW:0] rem_sub;
   logic        q_bit;

   // Each entry holds the maximum in the upper half and the minimum in the lower.
   mmscl_ram #(
      .WIDTH (2*VW),
      .DEPTH (NUM_FEATURES)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign idx_ext  = IDX_EXT_W'(idx_ff);
   assign rd_addr  = idx_ext[ADDR_W-1:0];
   assign in_range = 32'(idx_ff) < 32'(NUM_FEATURES);

   assign v_s  = val_ff;
   assign lo_s = rd_word[VW-1:0];
   assign hi_s = rd_word[2*VW-1:VW];

   assign diff_v = {val_ff[VW-1], val_ff} - {lo_s[VW-1], lo_s};
   assign span   = {hi_s[VW-1], hi_s} - {lo_s[VW-1], lo_s};

   assign new_lo = (v_s < lo_s) ? val_ff : lo_s;
   assign new_hi = (v_s > hi_s) ? val_ff : hi_s;

   assign wr_en   = cmd.clear_wr || (cmd.update_wr && in_range);
   assign wr_addr = cmd.clear_wr ? clr_addr_ff : rd_addr;
   assign wr_data = cmd.clear_wr ? {VAL_SMALLEST, VAL_LARGEST} : {new_hi, new_lo};

   // Results that need no division; an index beyond the store reads as a constant feature.
   always_comb begin
      direct_scaled = '0;
      direct_valid  = 1'b0;
      direct_clip   = 1'b0;
      need_div      = 1'b0;
      if (in_range && (lo_s < hi_s)) begin
         direct_valid = 1'b1;
         if (v_s < lo_s) begin
            direct_clip = 1'b1;
         end else if (v_s > hi_s) begin
            direct_scaled = '1;
            direct_clip   = 1'b1;
         end else if (v_s == hi_s) begin
            // The exact quotient is one whole, which saturates without clipping.
            direct_scaled = '1;
         end else begin
            need_div = 1'b1;
         end
      end
   end

   // One restoring step per cycle; the remainder always stays below the divisor.
   assign rem2    = {rem_ff, 1'b0};
   assign rem_sub = rem2 - {1'b0, den_ff};
   assign q_bit   = rem2 >= {1'b0, den_ff};

   always_comb begin
      op_in  = op_ff;
      idx_in = idx_ff;
      val_in = val_ff;
      if (cmd.accept) begin
         op_in  = req_operation;
         idx_in = req_feature_index;
         val_in = req_value;
      end

      quot_in      = quot_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      div_cnt_in   = div_cnt_ff;
      res_valid_in = res_valid_ff;
      res_clip_in  = res_clip_ff;
      if (cmd.set_result) begin
         quot_in      = direct_scaled;
         res_valid_in = direct_valid;
         res_clip_in  = direct_clip;
      end else if (cmd.div_start) begin
         quot_in      = '0;
         rem_in       = diff_v[VW-1:0];
         den_in       = span[VW-1:0];
         div_cnt_in   = '0;
         res_valid_in = 1'b1;
         res_clip_in  = 1'b0;
      end else if (cmd.div_step) begin
         quot_in    = {quot_ff[SCALED_W-2:0], q_bit};
         rem_in     = q_bit ? rem_sub[VW-1:0] : rem2[VW-1:0];
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      clr_addr_in = clr_addr_ff;
      if (cmd.clear_wr) begin
         clr_addr_in = clr_addr_ff + 1'b1;
      end

      rsp_valid_in       = rsp_valid_ff;
      rsp_scaled_in      = rsp_scaled_ff;
      rsp_range_valid_in = rsp_range_valid_ff;
      rsp_clipped_in     = rsp_clipped_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in       = 1'b1;
         rsp_scaled_in      = quot_ff;
         rsp_range_valid_in = res_valid_ff;
         rsp_clipped_in     = res_clip_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff   <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_cnt_ff   <= div_cnt_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff              <= op_in;
      idx_ff             <= idx_in;
      val_ff             <= val_in;
      quot_ff            <= quot_in;
      rem_ff             <= rem_in;
      den_ff             <= den_in;
      res_valid_ff       <= res_valid_in;
      res_clip_ff        <= res_clip_in;
      rsp_scaled_ff      <= rsp_scaled_in;
      rsp_range_valid_ff <= rsp_range_valid_in;
      rsp_clipped_ff     <= rsp_clipped_in;
   end

   assign sts.clear_last = clr_addr_ff == ADDR_W'(NUM_FEATURES - 1);
   assign sts.is_observe = op_ff == OP_OBSERVE;
   assign sts.need_div   = need_div;
   assign sts.div_last   = div_cnt_ff == DIV_CNT_W'(SCALED_W - 1);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scaled      = rsp_scaled_ff;
   assign rsp_range_valid = rsp_range_valid_ff;
   assign rsp_clipped     = rsp_clipped_ff;
endmodule

`default_nettype wire

@@ src/feature_min_max_scaler_core.sv @@
// Top level of the min-max feature scaler.
// Observe: the range is read and updated. Normalise: the range is read and compared,
// then the value is divided in 16 radix-2 steps unless clipped, at the maximum or of a
// constant feature; the result is loaded once the response register is free. The next
// request is taken in the cycle after the update or the load.
// Synchronous reset clears all NUM_FEATURES entries in a pass with req ready low.
`default_nettype none

module feature_min_max_scaler_core
   import mmscl_pkg::*;
#(
   parameter int NUM_FEATURES = 64,
   parameter int VALUE_WIDTH  = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mmscl_req_if.sink   req_chan,
   mmscl_rsp_if.source rsp_chan
);
   cmd_type cmd;
   sts_type sts;
   logic    req_ready;

   mmscl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mmscl_dpath #(
      .NUM_FEATURES (NUM_FEATURES),
      .VALUE_WIDTH  (VALUE_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_chan.operation),
      .req_feature_index (req_chan.feature_index),
      .req_value         (req_chan.value),
      .rsp_ready         (rsp_chan.ready),
      .rsp_valid         (rsp_chan.valid),
      .rsp_scaled        (rsp_chan.scaled),
      .rsp_range_valid   (rsp_chan.range_valid),
      .rsp_clipped       (rsp_chan.clipped)
   );

   assign req_chan.ready = req_ready;
endmodule

`default_nettype wire
